// File: src/stepper_power_mode_controller_top_defines.svh
// Assertion macros for the stepper power-mode controller.
// Included by the top level; define ASSERT_OFF to drop all checks.
`ifndef STEPPER_POWER_MODE_CONTROLLER_TOP_DEFINES_SVH
`define STEPPER_POWER_MODE_CONTROLLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define SPMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spmc assertion failed");
`define SPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spmc assertion failed");
`else
`define SPMC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define SPMC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/spmc_pkg.sv
// Shared types, codes and reset values for the stepper power-mode controller.
// No dependencies.
`timescale 1ns / 1ps
package spmc_pkg;

	localparam int CUR_CFG_W        = 12;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;

	localparam logic [1:0] MODE_OFF = 2'd0;
	localparam logic [1:0] MODE_SBC = 2'd1;
	localparam logic [1:0] MODE_FC  = 2'd2;
	localparam logic [1:0] MODE_ERR = 2'd3;

	localparam logic [2:0] MON_OFF   = 3'd0;
	localparam logic [2:0] MON_SBC   = 3'd1;
	localparam logic [2:0] MON_FC    = 3'd2;
	localparam logic [2:0] MON_TEMP  = 3'd3;
	localparam logic [2:0] MON_UNDER = 3'd4;
	localparam logic [2:0] MON_OVER  = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_AUTO_CURRENT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_CURRENT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STANDBY_CURRENT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TEMP        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER_VOLTAGE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER_VOLTAGE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_MODE       = 3'd7;

	localparam logic        RST_AUTO_CURRENT    = 1'b1;
	localparam logic [11:0] RST_FULL_CURRENT    = 12'd4095;
	localparam logic [11:0] RST_STANDBY_CURRENT = 12'd1024;
	localparam logic [7:0]  RST_IDLE_TIMEOUT    = 8'd10;
	localparam logic [7:0]  RST_MAX_TEMP        = 8'd80;
	localparam logic [15:0] RST_UPPER_VOLTAGE   = 16'd30000;
	localparam logic [15:0] RST_LOWER_VOLTAGE   = 16'd8000;
	localparam logic [3:0]  RST_STEP_MODE       = 4'd0;

	localparam logic [7:0] IDLE_MAX = 8'hFF;

	typedef struct packed {
		logic        auto_current;
		logic [11:0] fc_level;
		logic [11:0] sbc_level;
		logic [7:0]  idle_timeout;
		logic [7:0]  max_temp;
		logic [15:0] upper_voltage;
		logic [15:0] lower_voltage;
		logic [3:0]  step_mode;
	} cfg_t;

	typedef struct packed {
		logic        step_pulse;
		logic        idle_tick;
		logic [7:0]  heatsink_temp;
		logic [15:0] bus_voltage;
		logic        enable_changed;
		logic        enable_level;
		logic        cmd_error_reset;
		logic        cmd_activate;
		logic        cmd_deactivate;
	} item_t;

	typedef struct packed {
		logic [11:0] coil_current;
		logic        driver_enable;
		logic        driver_reset;
		logic [1:0]  drive_mode;
		logic [2:0]  monitor_code;
		logic [3:0]  step_mode_pins;
	} result_t;

endpackage

// File: src/spmc_cfg.sv
// Configuration register file of the stepper power-mode controller.
// Depends on spmc_pkg.
`timescale 1ns / 1ps
module spmc_cfg (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [spmc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [spmc_pkg::CFG_DATA_W-1:0]       cfg_data,
	output spmc_pkg::cfg_t                        cfg
);

	spmc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.auto_current    <= spmc_pkg::RST_AUTO_CURRENT;
			cfg_q.fc_level        <= spmc_pkg::RST_FULL_CURRENT;
			cfg_q.sbc_level       <= spmc_pkg::RST_STANDBY_CURRENT;
			cfg_q.idle_timeout    <= spmc_pkg::RST_IDLE_TIMEOUT;
			cfg_q.max_temp        <= spmc_pkg::RST_MAX_TEMP;
			cfg_q.upper_voltage   <= spmc_pkg::RST_UPPER_VOLTAGE;
			cfg_q.lower_voltage   <= spmc_pkg::RST_LOWER_VOLTAGE;
			cfg_q.step_mode       <= spmc_pkg::RST_STEP_MODE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spmc_pkg::REG_AUTO_CURRENT:    cfg_q.auto_current    <= cfg_data[0];
				spmc_pkg::REG_FULL_CURRENT:    cfg_q.fc_level        <= cfg_data[11:0];
				spmc_pkg::REG_STANDBY_CURRENT: cfg_q.sbc_level       <= cfg_data[11:0];
				spmc_pkg::REG_IDLE_TIMEOUT:    cfg_q.idle_timeout    <= cfg_data[7:0];
				spmc_pkg::REG_MAX_TEMP:        cfg_q.max_temp        <= cfg_data[7:0];
				spmc_pkg::REG_UPPER_VOLTAGE:   cfg_q.upper_voltage   <= cfg_data;
				spmc_pkg::REG_LOWER_VOLTAGE:   cfg_q.lower_voltage   <= cfg_data;
				spmc_pkg::REG_STEP_MODE:       cfg_q.step_mode       <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

// File: src/spmc_core.sv
// Mode state registers and per-word next-state logic of the power-mode controller.
// Depends on spmc_pkg.
`timescale 1ns / 1ps
module spmc_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  spmc_pkg::item_t   item,
	input  spmc_pkg::cfg_t    cfg,
	output spmc_pkg::result_t res
);

	logic [1:0] mode_q;
	logic [2:0] monitor_q;
	logic [7:0] idle_count_q;
	logic       idle_watch_q;
	logic       enable_q;
	logic       reset_q;
	logic [3:0] pins_q;

	logic [1:0] m;
	logic [2:0] mon;
	logic [7:0] cnt;
	logic       watch;
	logic       en;
	logic       rst;
	logic [3:0] pins;
	logic       v_nz;

	always_comb begin
		m     = mode_q;
		mon   = monitor_q;
		cnt   = idle_count_q;
		watch = idle_watch_q;
		en    = enable_q;
		rst   = reset_q;
		pins  = pins_q;
		v_nz  = (item.bus_voltage != 16'd0);

		// step pulse
		if (item.step_pulse && m == spmc_pkg::MODE_SBC && cfg.auto_current) begin
			watch = 1'b1;
			m     = spmc_pkg::MODE_FC;
			mon   = spmc_pkg::MON_FC;
		end

		// idle tick
		if (item.idle_tick && watch) begin
			if (item.step_pulse) begin
				cnt = 8'd0;
			end else begin
				if (cnt != spmc_pkg::IDLE_MAX)
					cnt = cnt + 8'd1;
				if (cnt > cfg.idle_timeout) begin
					watch = 1'b0;
					if (cfg.auto_current) begin
						m   = spmc_pkg::MODE_SBC;
						mon = spmc_pkg::MON_SBC;
						cnt = 8'd0;
					end else begin
						m   = spmc_pkg::MODE_FC;
						mon = spmc_pkg::MON_FC;
					end
				end
			end
		end

		// commands
		if (item.cmd_error_reset) begin
			rst = 1'b1;
			en  = 1'b0;
			m   = spmc_pkg::MODE_OFF;
			mon = spmc_pkg::MON_OFF;
		end
		if (item.cmd_activate) begin
			pins = cfg.step_mode;
			rst  = 1'b0;
			en   = 1'b1;
			if (cfg.auto_current) begin
				m   = spmc_pkg::MODE_SBC;
				mon = spmc_pkg::MON_SBC;
				cnt = 8'd0;
			end else begin
				m   = spmc_pkg::MODE_FC;
				mon = spmc_pkg::MON_FC;
			end
		end
		if (item.cmd_deactivate) begin
			rst = 1'b1;
			en  = 1'b0;
			m   = spmc_pkg::MODE_OFF;
			mon = spmc_pkg::MON_OFF;
		end

		// protection checks
		if ($signed(item.heatsink_temp) > $signed(cfg.max_temp) && m != spmc_pkg::MODE_ERR) begin
			rst = 1'b1;
			m   = spmc_pkg::MODE_ERR;
			mon = spmc_pkg::MON_TEMP;
		end
		if (v_nz && item.bus_voltage < cfg.lower_voltage && m != spmc_pkg::MODE_ERR) begin
			rst = 1'b1;
			m   = spmc_pkg::MODE_ERR;
			mon = spmc_pkg::MON_UNDER;
		end
		if (v_nz && item.bus_voltage > cfg.upper_voltage && m != spmc_pkg::MODE_ERR) begin
			rst = 1'b1;
			m   = spmc_pkg::MODE_ERR;
			mon = spmc_pkg::MON_OVER;
		end

		// enable pin, active low
		if (item.enable_changed && m != spmc_pkg::MODE_ERR) begin
			if (!item.enable_level) begin
				pins = cfg.step_mode;
				rst  = 1'b0;
				en   = 1'b1;
				if (cfg.auto_current) begin
					m   = spmc_pkg::MODE_SBC;
					mon = spmc_pkg::MON_SBC;
					cnt = 8'd0;
				end else begin
					m   = spmc_pkg::MODE_FC;
					mon = spmc_pkg::MON_FC;
				end
			end else begin
				rst = 1'b1;
				en  = 1'b0;
				m   = spmc_pkg::MODE_OFF;
				mon = spmc_pkg::MON_OFF;
			end
		end

		case (m)
			spmc_pkg::MODE_SBC: res.coil_current = cfg.sbc_level;
			spmc_pkg::MODE_FC:  res.coil_current = cfg.fc_level;
			default:            res.coil_current = 12'd0;
		endcase
		res.driver_enable  = en;
		res.driver_reset   = rst;
		res.drive_mode     = m;
		res.monitor_code   = mon;
		res.step_mode_pins = pins;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= spmc_pkg::MODE_OFF;
			monitor_q    <= spmc_pkg::MON_OFF;
			idle_count_q <= 8'd0;
			idle_watch_q <= 1'b0;
			enable_q     <= 1'b0;
			reset_q      <= 1'b1;
			pins_q       <= 4'd0;
		end else if (advance) begin
			mode_q       <= m;
			monitor_q    <= mon;
			idle_count_q <= cnt;
			idle_watch_q <= watch;
			enable_q     <= en;
			reset_q      <= rst;
			pins_q       <= pins;
		end
	end

endmodule

// File: src/stepper_power_mode_controller_top.sv
// Top level of the stepper power-mode controller: input register, core, result register.
// Depends on spmc_pkg, spmc_cfg, spmc_core and stepper_power_mode_controller_top_defines.svh.
//
// Usage:
//  - Input channel (in_valid / in_stall): one word per control-loop pass with the step,
//    tick, temperature, voltage, enable-pin and command fields.
//  - Output channel (out_valid / out_stall): one word per input word with coil current,
//    driver enable/reset, mode, monitor code and latched step-mode pins.
//  - Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready; write
//    only while no word is in flight.
//  - An accepted word is registered in the input register, then in the result register.
//  - Throughput: one word per cycle while out_stall is low; the mode update is a single
//    pass of compare and select logic between the input register and the result register.
//  - Out_stall holds the result register; the input register keeps accepting until it
//    is also full, then in_stall rises (combinationally from out_stall).
//  - Reset: mode off, driver held in reset, enable low, idle watch stopped, registers at
//    their defaults, both pipeline stages empty.
`timescale 1ns / 1ps
`include "stepper_power_mode_controller_top_defines.svh"
module stepper_power_mode_controller_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spmc_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              step_pulse,
	input  logic                              idle_tick,
	input  logic signed [7:0]                 heatsink_temp,
	input  logic [15:0]                       bus_voltage,
	input  logic                              enable_changed,
	input  logic                              enable_level,
	input  logic                              cmd_error_reset,
	input  logic                              cmd_activate,
	input  logic                              cmd_deactivate,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [spmc_pkg::CUR_CFG_W-1:0]    coil_current,
	output logic                              driver_enable,
	output logic                              driver_reset,
	output logic [1:0]                        drive_mode,
	output logic [2:0]                        monitor_code,
	output logic [3:0]                        step_mode_pins
);

	spmc_pkg::cfg_t    cfg;
	spmc_pkg::item_t   item_s1;
	spmc_pkg::result_t res;
	spmc_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              advance;

	spmc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	spmc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (!out_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.step_pulse      <= step_pulse;
			item_s1.idle_tick       <= idle_tick;
			item_s1.heatsink_temp   <= heatsink_temp;
			item_s1.bus_voltage     <= bus_voltage;
			item_s1.enable_changed  <= enable_changed;
			item_s1.enable_level    <= enable_level;
			item_s1.cmd_error_reset <= cmd_error_reset;
			item_s1.cmd_activate    <= cmd_activate;
			item_s1.cmd_deactivate  <= cmd_deactivate;
		end
		if (advance)
			res_s2 <= res;
	end

	assign out_valid      = valid_s2;
	assign coil_current   = res_s2.coil_current;
	assign driver_enable  = res_s2.driver_enable;
	assign driver_reset   = res_s2.driver_reset;
	assign drive_mode     = res_s2.drive_mode;
	assign monitor_code   = res_s2.monitor_code;
	assign step_mode_pins = res_s2.step_mode_pins;

	`SPMC_ASSERT_NOW(a_off_outputs, clk, arst_n,
		out_valid && drive_mode == spmc_pkg::MODE_OFF,
		driver_reset && !driver_enable && monitor_code == spmc_pkg::MON_OFF)
	`SPMC_ASSERT_NOW(a_err_cause, clk, arst_n,
		out_valid && drive_mode == spmc_pkg::MODE_ERR,
		driver_reset && (monitor_code == spmc_pkg::MON_TEMP ||
		monitor_code == spmc_pkg::MON_UNDER || monitor_code == spmc_pkg::MON_OVER))
	`SPMC_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n,
		in_stall, valid_s1 && valid_s2)

endmodule

// File: tb/sv/stepper_power_mode_controller_top_test.sv
// Self-checking testbench for the stepper power-mode controller top level.
// Depends on spmc_pkg and stepper_power_mode_controller_top; directed table, then random
// passes checked against a behavioral copy of the mode logic.
`timescale 1ns / 1ps
module stepper_power_mode_controller_top_test;

	typedef struct packed {
		spmc_pkg::item_t   word;
		logic              typed;
		spmc_pkg::result_t want;
	} drill_t;

	localparam int                PHASES     = 6;
	localparam int                PHASE_LEN  = 170;
	localparam int                QUIET_MAX  = 5000;
	localparam logic [15:0]       V_OK       = 16'd12000;
	localparam spmc_pkg::result_t NO_WANT    = '0;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	spmc_pkg::item_t in_word;
	logic        out_valid;
	logic        out_stall;
	logic [11:0] coil_current;
	logic        driver_enable;
	logic        driver_reset;
	logic [1:0]  drive_mode;
	logic [2:0]  monitor_code;
	logic [3:0]  step_mode_pins;

	// behavioral copy of the controller
	spmc_pkg::cfg_t cfg_sh;
	logic [1:0]  ctl_mode;
	logic [2:0]  ctl_mon;
	logic [7:0]  idle_ticks;
	logic        idle_armed;
	logic        en_q;
	logic        rst_q;
	logic [3:0]  pins_q;

	spmc_pkg::result_t pending_status[$];
	int          errs = 0;
	int          tx_idle_pct;
	int          rx_idle_pct;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stepper_power_mode_controller_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.step_pulse     (in_word.step_pulse),
		.idle_tick      (in_word.idle_tick),
		.heatsink_temp  (in_word.heatsink_temp),
		.bus_voltage    (in_word.bus_voltage),
		.enable_changed (in_word.enable_changed),
		.enable_level   (in_word.enable_level),
		.cmd_error_reset(in_word.cmd_error_reset),
		.cmd_activate   (in_word.cmd_activate),
		.cmd_deactivate (in_word.cmd_deactivate),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.coil_current   (coil_current),
		.driver_enable  (driver_enable),
		.driver_reset   (driver_reset),
		.drive_mode     (drive_mode),
		.monitor_code   (monitor_code),
		.step_mode_pins (step_mode_pins)
	);

	function automatic void shut_off();
		rst_q    = 1'b1;
		en_q     = 1'b0;
		ctl_mode = spmc_pkg::MODE_OFF;
		ctl_mon  = spmc_pkg::MON_OFF;
	endfunction

	function automatic void enter_standby();
		if (cfg_sh.auto_current) begin
			ctl_mode   = spmc_pkg::MODE_SBC;
			ctl_mon    = spmc_pkg::MON_SBC;
			idle_ticks = '0;
		end else begin
			ctl_mode = spmc_pkg::MODE_FC;
			ctl_mon  = spmc_pkg::MON_FC;
		end
	endfunction

	function automatic void activate();
		pins_q = cfg_sh.step_mode;
		rst_q  = 1'b0;
		en_q   = 1'b1;
		enter_standby();
	endfunction

	function automatic void trip(input logic [2:0] cause);
		rst_q    = 1'b1;
		ctl_mode = spmc_pkg::MODE_ERR;
		ctl_mon  = cause;
	endfunction

	function automatic spmc_pkg::result_t step_controller(input spmc_pkg::item_t w);
		spmc_pkg::result_t r;
		if (w.step_pulse && ctl_mode == spmc_pkg::MODE_SBC && cfg_sh.auto_current) begin
			idle_armed = 1'b1;
			ctl_mode   = spmc_pkg::MODE_FC;
			ctl_mon    = spmc_pkg::MON_FC;
		end
		if (w.idle_tick && idle_armed) begin
			if (w.step_pulse) begin
				idle_ticks = '0;
			end else begin
				if (idle_ticks != spmc_pkg::IDLE_MAX)
					idle_ticks = idle_ticks + 8'd1;
				if (idle_ticks > cfg_sh.idle_timeout) begin
					idle_armed = 1'b0;
					enter_standby();
				end
			end
		end
		if (w.cmd_error_reset)
			shut_off();
		if (w.cmd_activate)
			activate();
		if (w.cmd_deactivate)
			shut_off();
		if ($signed(w.heatsink_temp) > $signed(cfg_sh.max_temp) &&
				ctl_mode != spmc_pkg::MODE_ERR)
			trip(spmc_pkg::MON_TEMP);
		if (w.bus_voltage != 16'd0) begin
			if (w.bus_voltage < cfg_sh.lower_voltage && ctl_mode != spmc_pkg::MODE_ERR)
				trip(spmc_pkg::MON_UNDER);
			if (w.bus_voltage > cfg_sh.upper_voltage && ctl_mode != spmc_pkg::MODE_ERR)
				trip(spmc_pkg::MON_OVER);
		end
		if (w.enable_changed && ctl_mode != spmc_pkg::MODE_ERR) begin
			if (!w.enable_level)
				activate();
			else
				shut_off();
		end
		if (ctl_mode == spmc_pkg::MODE_SBC)
			r.coil_current = cfg_sh.sbc_level;
		else if (ctl_mode == spmc_pkg::MODE_FC)
			r.coil_current = cfg_sh.fc_level;
		else
			r.coil_current = '0;
		r.driver_enable  = en_q;
		r.driver_reset   = rst_q;
		r.drive_mode     = ctl_mode;
		r.monitor_code   = ctl_mon;
		r.step_mode_pins = pins_q;
		return r;
	endfunction

	function automatic spmc_pkg::item_t pass_of(input int pulse, input int tick,
			input logic [7:0] temp, input logic [15:0] volt, input int chg, input int lvl,
			input int err, input int act, input int deact);
		return {1'(pulse), 1'(tick), temp, volt, 1'(chg), 1'(lvl), 1'(err), 1'(act),
			1'(deact)};
	endfunction

	function automatic spmc_pkg::result_t status_of(input logic [11:0] cur, input int en,
			input int rst, input logic [1:0] md, input logic [2:0] mon,
			input logic [3:0] pins);
		return {cur, 1'(en), 1'(rst), md, mon, pins};
	endfunction

	// mostly plausible loop passes; some raw noise and out-of-range samples
	function automatic spmc_pkg::item_t forge_word();
		spmc_pkg::item_t w;
		logic [31:0] raw;
		int          lim;
		int          pick;
		raw = $urandom;
		w = raw[$bits(spmc_pkg::item_t)-1:0];
		if ($urandom_range(99, 0) < 12)
			return w;
		w.step_pulse = $urandom_range(99, 0) < 30;
		w.idle_tick  = $urandom_range(99, 0) < 55;
		lim = int'($signed(cfg_sh.max_temp));
		if ($urandom_range(99, 0) >= 4)
			w.heatsink_temp = 8'(int'($urandom_range(lim + 128, 0)) - 128);
		pick = $urandom_range(99, 0);
		if (pick < 10)
			w.bus_voltage = 16'd0;
		else if (pick >= 14) begin
			if (cfg_sh.lower_voltage <= cfg_sh.upper_voltage)
				w.bus_voltage = 16'($urandom_range(cfg_sh.upper_voltage, cfg_sh.lower_voltage));
			else
				w.bus_voltage = 16'd0;
		end
		w.enable_changed  = $urandom_range(99, 0) < 6;
		w.cmd_error_reset = $urandom_range(99, 0) < 3;
		if (ctl_mode == spmc_pkg::MODE_OFF || ctl_mode == spmc_pkg::MODE_ERR)
			w.cmd_activate = $urandom_range(99, 0) < 25;
		else
			w.cmd_activate = $urandom_range(99, 0) < 3;
		w.cmd_deactivate = $urandom_range(99, 0) < 3;
		return w;
	endfunction

	function automatic void cmp_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errs++;
		end
	endfunction

	task automatic put_word(input spmc_pkg::item_t w, input logic typed,
			input spmc_pkg::result_t typed_want);
		spmc_pkg::result_t want;
		while ($urandom_range(99, 0) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		want = step_controller(w);
		pending_status.push_back(typed ? typed_want : want);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
		logic [15:0] mask;
		logic [15:0] junk;
		junk = 16'($urandom);
		case (idx)
			spmc_pkg::REG_AUTO_CURRENT:                           mask = 16'h0001;
			spmc_pkg::REG_FULL_CURRENT, spmc_pkg::REG_STANDBY_CURRENT: mask = 16'h0FFF;
			spmc_pkg::REG_IDLE_TIMEOUT, spmc_pkg::REG_MAX_TEMP:   mask = 16'h00FF;
			spmc_pkg::REG_STEP_MODE:                              mask = 16'h000F;
			default:                                              mask = 16'hFFFF;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= (value & mask) | (junk & ~mask);
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			spmc_pkg::REG_AUTO_CURRENT:    cfg_sh.auto_current  = value[0];
			spmc_pkg::REG_FULL_CURRENT:    cfg_sh.fc_level      = value[11:0];
			spmc_pkg::REG_STANDBY_CURRENT: cfg_sh.sbc_level     = value[11:0];
			spmc_pkg::REG_IDLE_TIMEOUT:    cfg_sh.idle_timeout  = value[7:0];
			spmc_pkg::REG_MAX_TEMP:        cfg_sh.max_temp      = value[7:0];
			spmc_pkg::REG_UPPER_VOLTAGE:   cfg_sh.upper_voltage = value;
			spmc_pkg::REG_LOWER_VOLTAGE:   cfg_sh.lower_voltage = value;
			default:                       cfg_sh.step_mode     = value[3:0];
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_status.size() != 0)
			@(posedge clk);
	endtask

	// receiver: random stalls plus two long hold-offs
	initial begin : sink
		int took;
		int hold_left;
		took = 0;
		hold_left = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				took++;
				if (took == 150 || took == 700)
					hold_left = 60;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= $urandom_range(99, 0) < rx_idle_pct;
			end
		end
	end

	always @(posedge clk) begin : score
		spmc_pkg::result_t seen;
		spmc_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			seen = {coil_current, driver_enable, driver_reset, drive_mode, monitor_code,
				step_mode_pins};
			if (pending_status.size() == 0) begin
				$error("status word %h with none outstanding", seen);
				errs++;
			end else begin
				want = pending_status.pop_front();
				cmp_field("coil_current", want.coil_current, seen.coil_current);
				cmp_field("driver_enable", want.driver_enable, seen.driver_enable);
				cmp_field("driver_reset", want.driver_reset, seen.driver_reset);
				cmp_field("drive_mode", want.drive_mode, seen.drive_mode);
				cmp_field("monitor_code", want.monitor_code, seen.monitor_code);
				cmp_field("step_mode_pins", want.step_mode_pins, seen.step_mode_pins);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		int quiet;
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin : main
		drill_t         drill_tab[$];
		spmc_pkg::cfg_t plan;
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		in_word     = '0;
		cfg_valid   = 1'b0;
		cfg_index   = spmc_pkg::REG_AUTO_CURRENT;
		cfg_data    = '0;
		tx_idle_pct = 35;
		rx_idle_pct = 49;
		cfg_sh = {spmc_pkg::RST_AUTO_CURRENT, spmc_pkg::RST_FULL_CURRENT,
			spmc_pkg::RST_STANDBY_CURRENT, spmc_pkg::RST_IDLE_TIMEOUT,
			spmc_pkg::RST_MAX_TEMP, spmc_pkg::RST_UPPER_VOLTAGE,
			spmc_pkg::RST_LOWER_VOLTAGE, spmc_pkg::RST_STEP_MODE};
		ctl_mode   = spmc_pkg::MODE_OFF;
		ctl_mon    = spmc_pkg::MON_OFF;
		idle_ticks = '0;
		idle_armed = 1'b0;
		en_q       = 1'b0;
		rst_q      = 1'b1;
		pins_q     = '0;

		// pulse, tick, temp, volt, en_chg, en_lvl, err_rst, act, deact
		drill_tab.push_back({pass_of(0, 0, 8'd25, 16'd0, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 0, 1, spmc_pkg::MODE_OFF, spmc_pkg::MON_OFF, 4'd0)});
		drill_tab.push_back({pass_of(1, 1, 8'd25, V_OK, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 0, 1, spmc_pkg::MODE_OFF, spmc_pkg::MON_OFF, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 0, 1, 0), 1'b1,
			status_of(12'd1024, 1, 0, spmc_pkg::MODE_SBC, spmc_pkg::MON_SBC, 4'd0)});
		drill_tab.push_back({pass_of(1, 0, 8'd25, V_OK, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd4095, 1, 0, spmc_pkg::MODE_FC, spmc_pkg::MON_FC, 4'd0)});
		drill_tab.push_back({pass_of(0, 1, 8'd25, V_OK, 0, 0, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(1, 1, 8'd25, V_OK, 0, 0, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd127, V_OK, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 1, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_TEMP, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 1, 0, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 1, 0, 0), 1'b1,
			status_of(12'd0, 0, 1, spmc_pkg::MODE_OFF, spmc_pkg::MON_OFF, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 1, 0, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd25, 16'd1, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 1, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_UNDER, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 1, 1, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd25, 16'hFFFF, 0, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 1, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_OVER, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 1, 1, 1), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'h80, 16'd0, 0, 0, 0, 1, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 1, 8'd80, 16'd8000, 0, 0, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd80, 16'd30000, 1, 1, 0, 0, 0), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 0, 1, 1), 1'b0, NO_WANT});
		drill_tab.push_back({pass_of(0, 0, 8'd81, V_OK, 1, 0, 0, 0, 0), 1'b1,
			status_of(12'd0, 0, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_TEMP, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, 16'd7999, 0, 0, 1, 0, 0), 1'b1,
			status_of(12'd0, 0, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_UNDER, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, 16'd30001, 0, 0, 0, 1, 0), 1'b1,
			status_of(12'd0, 1, 1, spmc_pkg::MODE_ERR, spmc_pkg::MON_OVER, 4'd0)});
		drill_tab.push_back({pass_of(0, 0, 8'd25, V_OK, 0, 0, 0, 0, 1), 1'b0, NO_WANT});

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (drill_tab[i])
			put_word(drill_tab[i].word, drill_tab[i].typed, drill_tab[i].want);

		for (int p = 0; p < PHASES; p++) begin
			tx_idle_pct = (p < 2) ? 35 : (p < 4) ? 49 : 0;
			rx_idle_pct = (p < 2) ? 49 : (p < 4) ? 35 : 0;
			drain();
			case (p)
				0: plan = {1'b0, 12'd0, 12'd0, 8'd0, 8'h80, 16'd0, 16'd0, 4'd0};
				1: plan = {1'b1, 12'hFFF, 12'hFFF, 8'hFF, 8'h7F, 16'hFFFF, 16'hFFFF, 4'hF};
				2: plan = {1'b1, 12'($urandom), 12'($urandom), 8'd0,
					8'($urandom_range(120, 30)), 16'($urandom_range(65535, 20000)),
					16'($urandom_range(12000, 1)), 4'($urandom)};
				3: plan = {1'b1, 12'($urandom), 12'($urandom), 8'($urandom_range(5, 1)),
					8'($urandom_range(120, 30)), 16'($urandom_range(65535, 20000)),
					16'($urandom_range(12000, 1)), 4'($urandom)};
				4: plan = {1'b0, 12'($urandom), 12'($urandom), 8'($urandom_range(6, 0)),
					8'($urandom_range(120, 30)), 16'($urandom_range(65535, 20000)),
					16'($urandom_range(12000, 1)), 4'($urandom)};
				default: plan = {1'b1, 12'($urandom), 12'($urandom), 8'($urandom_range(8, 0)),
					8'($urandom), 16'($urandom), 16'($urandom), 4'($urandom)};
			endcase
			put_reg(spmc_pkg::REG_AUTO_CURRENT, {15'd0, plan.auto_current});
			put_reg(spmc_pkg::REG_FULL_CURRENT, {4'd0, plan.fc_level});
			put_reg(spmc_pkg::REG_STANDBY_CURRENT, {4'd0, plan.sbc_level});
			put_reg(spmc_pkg::REG_IDLE_TIMEOUT, {8'd0, plan.idle_timeout});
			put_reg(spmc_pkg::REG_MAX_TEMP, {8'd0, plan.max_temp});
			put_reg(spmc_pkg::REG_UPPER_VOLTAGE, plan.upper_voltage);
			put_reg(spmc_pkg::REG_LOWER_VOLTAGE, plan.lower_voltage);
			put_reg(spmc_pkg::REG_STEP_MODE, {12'd0, plan.step_mode});
			cfg_valid <= 1'b0;
			for (int n = 0; n < PHASE_LEN; n++)
				put_word(forge_word(), 1'b0, NO_WANT);
		end

		drain();
		repeat (8) @(posedge clk);
		if (errs == 0 && pending_status.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
